// ----- rtl/grb_pkg.sv -----
// Shared types and constants of the glyph row blitter.
package grb_pkg;

  localparam int GLYPH_ROWS_DEF = 16;
  localparam int CHAR_COUNT_DEF = 256;

  // Depth of the command queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [12:0] RESET_WIDTH  = 13'd1024;
  localparam logic [12:0] RESET_HEIGHT = 13'd768;
  localparam logic [14:0] RESET_PITCH  = 15'd4096;
  localparam logic [5:0]  RESET_DEPTH  = 6'd32;

  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_LINE_PITCH    = 2'd2,
    CFG_PIXEL_DEPTH   = 2'd3
  } cfg_idx_e;

  localparam logic [5:0] DEPTH_8BPP  = 6'd8;
  localparam logic [5:0] DEPTH_16BPP = 6'd16;
  localparam logic [5:0] DEPTH_24BPP = 6'd24;
  localparam logic [5:0] DEPTH_32BPP = 6'd32;

  // Screen geometry seen by the back end.
  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [14:0] pitch;
  } grb_geom_t;

  // Classified command travelling through the queue.
  typedef struct packed {
    logic               is_draw;
    logic               code_ok;
    logic               depth_ok;
    logic [7:0]         char_code;
    logic [3:0]         load_row;
    logic [7:0]         load_bits;
    logic signed [12:0] pos_x;
    logic signed [12:0] pos_y;
    logic [31:0]        value;
    logic [2:0]         bytes;
  } grb_cmd_t;

endpackage

// ----- rtl/grb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module grb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/grb_front.sv -----
// Front end: configuration registers, input acceptance and command classification.
module grb_front #(
  parameter int GLYPH_ROWS = grb_pkg::GLYPH_ROWS_DEF,
  parameter int CHAR_COUNT = grb_pkg::CHAR_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [grb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [grb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_mode_i,
  input  logic [79:0]                    in_data_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output grb_pkg::grb_cmd_t              q_cmd_o,
  output grb_pkg::grb_geom_t             geom_o
);

  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [14:0] pitch_q;
  logic [5:0]  depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= grb_pkg::RESET_WIDTH;
      height_q <= grb_pkg::RESET_HEIGHT;
      pitch_q  <= grb_pkg::RESET_PITCH;
      depth_q  <= grb_pkg::RESET_DEPTH;
    end else if (cfg_we_i) begin
      case (grb_pkg::cfg_idx_e'(cfg_idx_i))
        grb_pkg::CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i[12:0];
        grb_pkg::CFG_SCREEN_HEIGHT: height_q <= cfg_data_i[12:0];
        grb_pkg::CFG_LINE_PITCH:    pitch_q  <= cfg_data_i[14:0];
        grb_pkg::CFG_PIXEL_DEPTH:   depth_q  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign geom_o.width  = width_q;
  assign geom_o.height = height_q;
  assign geom_o.pitch  = pitch_q;

  logic [31:0] ink;
  logic        load_ok;

  assign ink = in_data_i[77:46];

  always_comb begin
    q_cmd_o.is_draw   = in_mode_i;
    q_cmd_o.char_code = in_data_i[7:0];
    q_cmd_o.load_row  = in_data_i[11:8];
    q_cmd_o.load_bits = in_data_i[19:12];
    q_cmd_o.pos_x     = in_data_i[32:20];
    q_cmd_o.pos_y     = in_data_i[45:33];
    q_cmd_o.code_ok   = (32'(in_data_i[7:0]) < CHAR_COUNT);
    q_cmd_o.depth_ok  = 1'b1;
    case (depth_q)
      grb_pkg::DEPTH_32BPP: begin
        q_cmd_o.value = ink;
        q_cmd_o.bytes = 3'd4;
      end
      grb_pkg::DEPTH_24BPP: begin
        q_cmd_o.value = {8'h00, ink[23:0]};
        q_cmd_o.bytes = 3'd3;
      end
      grb_pkg::DEPTH_16BPP: begin
        // RGB565: top bits of each colour byte
        q_cmd_o.value = {16'h0000, ink[23:19], ink[15:10], ink[7:3]};
        q_cmd_o.bytes = 3'd2;
      end
      grb_pkg::DEPTH_8BPP: begin
        q_cmd_o.value = {24'h000000, ink[7:0]};
        q_cmd_o.bytes = 3'd1;
      end
      default: begin
        q_cmd_o.value    = '0;
        q_cmd_o.bytes    = '0;
        q_cmd_o.depth_ok = 1'b0;
      end
    endcase
  end

  // Drop loads aimed outside the font store.
  assign load_ok    = q_cmd_o.code_ok && (32'(in_data_i[11:8]) < GLYPH_ROWS);
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && in_ready_o && (in_mode_i || load_ok);

endmodule

// ----- rtl/grb_queue.sv -----
// Short command queue between front and back end.
module grb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  grb_pkg::grb_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output grb_pkg::grb_cmd_t cmd_o
);

  localparam int PtrW = (grb_pkg::QUEUE_DEPTH > 1) ? $clog2(grb_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(grb_pkg::QUEUE_DEPTH + 1);

  grb_pkg::grb_cmd_t slot_q [grb_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (32'(p) == grb_pkg::QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (32'(count_q) == grb_pkg::QUEUE_DEPTH);
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/grb_back.sv -----
// Back end: font store, row sequencer, clipping and the output register.
module grb_back #(
  parameter int GLYPH_ROWS = grb_pkg::GLYPH_ROWS_DEF,
  parameter int CHAR_COUNT = grb_pkg::CHAR_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grb_pkg::grb_geom_t geom_i,
  input  logic               q_valid_i,
  input  grb_pkg::grb_cmd_t  q_cmd_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_last_o,
  output logic [87:0]        out_data_o
);

  localparam int RowW  = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int Depth = CHAR_COUNT * GLYPH_ROWS;
  localparam int AddrW = $clog2(Depth);

  // Sequencer
  logic              busy_q, busy_d;
  logic [RowW-1:0]   row_q, row_d;
  grb_pkg::grb_cmd_t ent_q, ent_d;
  grb_pkg::grb_cmd_t cur;
  logic [RowW-1:0]   cur_row;
  logic              head_draw, head_load, adv, issue, is_last;
  logic [AddrW-1:0]  rd_addr, wr_addr;
  logic [7:0]        glyph;

  assign adv       = !out_valid_o || out_ready_i;
  assign head_draw = q_valid_i && q_cmd_i.is_draw;
  assign head_load = q_valid_i && !q_cmd_i.is_draw;
  assign cur       = busy_q ? ent_q : q_cmd_i;
  assign cur_row   = busy_q ? row_q : '0;
  assign issue     = adv && (busy_q || head_draw);
  assign is_last   = (cur_row == RowW'(GLYPH_ROWS - 1));
  assign q_pop_o   = !busy_q && (head_load || (head_draw && adv));

  assign rd_addr = cur.code_ok ? AddrW'(cur.char_code * GLYPH_ROWS + cur_row) : '0;
  assign wr_addr = AddrW'(q_cmd_i.char_code * GLYPH_ROWS + q_cmd_i.load_row);

  grb_ram #(
    .WIDTH(8),
    .DEPTH(Depth)
  ) u_font (
    .clk_i  (clk_i),
    .we_i   (!busy_q && head_load),
    .waddr_i(wr_addr),
    .wdata_i(q_cmd_i.load_bits),
    .re_i   (issue),
    .raddr_i(rd_addr),
    .rdata_o(glyph)
  );

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    ent_d  = ent_q;
    if (issue) begin
      ent_d = cur;
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
        row_d  = cur_row + 1'b1;
      end
    end
  end

  // Row stage: metadata alongside the glyph read
  logic               s1_valid_q;
  logic               s1_last_q;
  logic               s1_code_ok_q;
  logic               s1_depth_ok_q;
  logic signed [13:0] s1_line_q;
  logic signed [12:0] s1_px_q;
  logic [31:0]        s1_value_q;
  logic [2:0]         s1_bytes_q;

  // Output stage
  logic               out_valid_q;
  logic               out_last_q;
  logic [25:0]        out_offset_q, out_offset_d;
  logic signed [12:0] out_col_q;
  logic [7:0]         out_mask_q, out_mask_d;
  logic [31:0]        out_value_q;
  logic [2:0]         out_bytes_q;

  logic        line_ok;
  logic [27:0] prod;
  logic [13:0] col;

  assign line_ok = !s1_line_q[13] && (s1_line_q[12:0] < geom_i.height);
  assign prod    = s1_line_q[12:0] * geom_i.pitch;

  always_comb begin
    out_offset_d = line_ok ? prod[25:0] : '0;
    out_mask_d   = '0;
    col          = '0;
    for (int k = 0; k < 8; k++) begin
      col = {s1_px_q[12], s1_px_q} + 14'(k);
      out_mask_d[7-k] = glyph[7-k] && !col[13] && (col[12:0] < geom_i.width);
    end
    // Clip the whole row off screen, or for a bad depth or character
    if (!(line_ok && s1_code_ok_q && s1_depth_ok_q)) begin
      out_mask_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      row_q  <= row_d;
      if (adv) begin
        s1_valid_q  <= issue;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (adv) begin
      s1_last_q     <= is_last;
      s1_code_ok_q  <= cur.code_ok;
      s1_depth_ok_q <= cur.depth_ok;
      s1_line_q     <= {cur.pos_y[12], cur.pos_y} + 14'(cur_row);
      s1_px_q       <= cur.pos_x;
      s1_value_q    <= cur.value;
      s1_bytes_q    <= cur.bytes;
      out_last_q    <= s1_last_q;
      out_offset_q  <= out_offset_d;
      out_col_q     <= s1_px_q;
      out_mask_q    <= out_mask_d;
      out_value_q   <= s1_value_q;
      out_bytes_q   <= s1_bytes_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {6'b0, out_bytes_q, out_value_q, out_mask_q, out_col_q, out_offset_q};

  // A busy sequencer has always issued row zero already
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (row_q != '0) && (32'(row_q) < GLYPH_ROWS))
    else $error("row counter out of range while busy");

  // Font writes only happen between characters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && head_load) |-> !issue)
    else $error("font write collides with a row read");

  // Issuing the final row frees the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && is_last) |=> !busy_q)
    else $error("sequencer still busy after last row");

  // A stalled result keeps the row stage frozen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && s1_valid_q) |=> s1_valid_q && $stable(s1_line_q))
    else $error("row stage moved under a stall");

endmodule

// ----- rtl/glyph_row_blitter_unit.sv -----
// Top level of the glyph row blitter: character generator for a framebuffer.
//
// Input stream s_axis: tuser is the mode (0 load a glyph row, 1 draw a
// character). A load writes one byte of the font store and yields nothing; a
// draw yields GLYPH_ROWS results on m_axis, top row first, with tlast on the
// final row. Each result carries the line's byte offset, the start column, a
// clipped 8-pixel write mask and the ink colour packed for the pixel depth.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while the
// block is idle.
// Throughput: a draw reads one font row per cycle through the single read port
// of the font RAM while m_axis does not stall; a load writes the font store between characters.
// The first row of a draw reaches m_axis after the item is accepted, behind
// the command queue, the font read and the output register.
// Reset clears the queue, the sequencer and the output register and restores
// the default geometry (1024 x 768, pitch 4096, 32 bpp); font contents are
// undefined until loaded. When m_axis stalls the result holds, the row
// sequencer waits, and items keep being accepted until the queue fills.
module glyph_row_blitter_unit #(
  parameter int GLYPH_ROWS = grb_pkg::GLYPH_ROWS_DEF,
  parameter int CHAR_COUNT = grb_pkg::CHAR_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [grb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [grb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // char_code[7:0], load_row[11:8], load_bits[19:12], pos_x[32:20],
  // pos_y[45:33], ink_color[77:46], zero fill[79:78]
  input  logic [79:0]                    s_axis_tdata,
  // mode[0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // row_offset[25:0], first_column[38:26], pixel_mask[46:39],
  // pixel_value[78:47], pixel_bytes[81:79], zero fill[87:82]
  output logic [87:0]                    m_axis_tdata,
  output logic                           m_axis_tlast
);

  grb_pkg::grb_cmd_t  push_cmd, head_cmd;
  grb_pkg::grb_geom_t geom;
  logic               push, full, pop, head_valid;

  grb_front #(
    .GLYPH_ROWS(GLYPH_ROWS),
    .CHAR_COUNT(CHAR_COUNT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_mode_i (s_axis_tuser),
    .in_data_i (s_axis_tdata),
    .q_full_i  (full),
    .q_push_o  (push),
    .q_cmd_o   (push_cmd),
    .geom_o    (geom)
  );

  grb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .cmd_o  (head_cmd)
  );

  grb_back #(
    .GLYPH_ROWS(GLYPH_ROWS),
    .CHAR_COUNT(CHAR_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .geom_i     (geom),
    .q_valid_i  (head_valid),
    .q_cmd_i    (head_cmd),
    .q_pop_o    (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_last_o (m_axis_tlast),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ----- verif/glyph_row_blitter_tb.sv -----
// Self-checking testbench of the glyph row blitter: random loads and draws checked row by row.
`timescale 1ns / 100ps

module testbench;

  localparam int ROWS_PER_GLYPH = grb_pkg::GLYPH_ROWS_DEF;
  localparam int IDLE_PCT       = 37;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_ITEMS    = 16;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  localparam logic [5:0] DEPTH_NONE = 6'd0;
  localparam logic [5:0] DEPTH_ODD  = 6'd20;

  typedef struct {
    logic        mode;
    logic [79:0] data;
  } blit_cmd_t;

  typedef struct {
    logic [25:0] row_offset;
    logic [12:0] first_column;
    logic [7:0]  pixel_mask;
    logic [31:0] pixel_value;
    logic [2:0]  pixel_bytes;
    logic        last_row;
  } row_result_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [grb_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [grb_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [79:0]                    s_axis_tdata;
  logic                           s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [87:0]                    m_axis_tdata;
  logic                           m_axis_tlast;

  glyph_row_blitter_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Screen settings walked through after the default one; the last is drawn at random
  int         set_width  [7] = '{4096, 1, 640, 800, 37, 4096, 0};
  int         set_height [7] = '{4096, 1, 480, 600, 21, 4096, 0};
  int         set_pitch  [7] = '{16384, 1, 1280, 2400, 16384, 16384, 0};
  logic [5:0] set_depth  [7] = '{grb_pkg::DEPTH_32BPP, grb_pkg::DEPTH_8BPP,
                                 grb_pkg::DEPTH_16BPP, grb_pkg::DEPTH_24BPP,
                                 DEPTH_NONE, DEPTH_ODD, grb_pkg::DEPTH_32BPP};
  logic [7:0] edge_glyph [16] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F,
                                  8'h81, 8'h7E, 8'hC3, 8'h3C, 8'hFF, 8'h18, 8'hE7, 8'hFF};

  // Blitter state as the block should hold it
  logic [7:0] font_copy [0:4095];
  int         width_cfg  = grb_pkg::RESET_WIDTH;
  int         height_cfg = grb_pkg::RESET_HEIGHT;
  int         pitch_cfg  = grb_pkg::RESET_PITCH;
  logic [5:0] depth_cfg  = grb_pkg::RESET_DEPTH;

  // Glyph rows written so far, so that only fully loaded characters are drawn
  logic [15:0] rows_loaded [256];
  logic        char_ready  [256];
  logic [7:0]  ready_chars [$];

  blit_cmd_t   cmd_backlog [$];
  blit_cmd_t   pending_cmd;
  row_result_t row_results_due [$];

  logic in_taken    = 1'b0;
  logic quiet_sides = 1'b0;
  int   quiet_cycles;
  int   mismatches;
  int   rows_checked;
  int   loads_sent;
  int   draws_sent;
  int   settings_used;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic queue_load(input logic [7:0] code, input logic [3:0] row,
                            input logic [7:0] bits);
    blit_cmd_t c;
    c.mode = MODE_LOAD;
    c.data = {2'b00, 32'h0, 13'h0, 13'h0, bits, row, code};
    cmd_backlog.push_back(c);
    loads_sent++;
    rows_loaded[code][row] = 1'b1;
    if (rows_loaded[code] == 16'hFFFF && !char_ready[code]) begin
      char_ready[code] = 1'b1;
      ready_chars.push_back(code);
    end
  endtask

  task automatic queue_draw(input logic [7:0] code, input logic [12:0] x,
                            input logic [12:0] y, input logic [31:0] ink);
    blit_cmd_t c;
    c.mode = MODE_DRAW;
    c.data = {2'b00, ink, y, x, 8'h00, 4'h0, code};
    cmd_backlog.push_back(c);
    draws_sent++;
  endtask

  // Bias coordinates towards the clip boundaries at 0 and at the screen size
  function automatic logic [12:0] rand_coord(input int span);
    case ($urandom_range(3))
      0:       return 13'($urandom);
      1:       return 13'(int'($urandom_range(24)) - 12);
      2:       return 13'(span - 12 + int'($urandom_range(16)));
      default: return 13'($urandom_range(span));
    endcase
  endfunction

  task automatic random_items(input int budget);
    int         n;
    int         pick;
    logic [7:0] code;
    n = 0;
    while (n < budget) begin
      pick = $urandom_range(99);
      if (pick < 10 || ready_chars.size() == 0) begin
        code = 8'($urandom);
        for (int r = 0; r < ROWS_PER_GLYPH; r++) queue_load(code, 4'(r), 8'($urandom));
        n += ROWS_PER_GLYPH;
      end else if (pick < 22) begin
        queue_load(8'($urandom), 4'($urandom), 8'($urandom));
        n++;
      end else begin
        code = ready_chars[$urandom_range(ready_chars.size() - 1)];
        queue_draw(code, rand_coord(width_cfg), rand_coord(height_cfg), $urandom);
        n++;
      end
    end
  endtask

  task automatic write_reg(input grb_pkg::cfg_idx_e idx, input int value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= grb_pkg::CFG_DATA_W'(value);
    case (idx)
      grb_pkg::CFG_SCREEN_WIDTH:  width_cfg  = value & 'h1FFF;
      grb_pkg::CFG_SCREEN_HEIGHT: height_cfg = value & 'h1FFF;
      grb_pkg::CFG_LINE_PITCH:    pitch_cfg  = value & 'h7FFF;
      grb_pkg::CFG_PIXEL_DEPTH:   depth_cfg  = 6'(value);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every item is in and every row is out, then let loads drain
  task automatic settle();
    while (cmd_backlog.size() != 0 || s_axis_tvalid || row_results_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic predict_rows(input logic mode, input logic [79:0] data);
    logic [7:0]         code;
    logic signed [12:0] px;
    logic signed [12:0] py;
    logic [31:0]        ink;
    logic [31:0]        value;
    logic [2:0]         nbytes;
    logic               depth_ok;
    logic [7:0]         glyph;
    int                 line;
    int                 col;
    row_result_t        r;
    code = data[7:0];
    px   = data[32:20];
    py   = data[45:33];
    ink  = data[77:46];
    if (mode == MODE_LOAD) begin
      font_copy[{code, data[11:8]}] = data[19:12];
    end else begin
      depth_ok = 1'b1;
      case (depth_cfg)
        grb_pkg::DEPTH_32BPP: begin value = ink;                nbytes = 3'd4; end
        grb_pkg::DEPTH_24BPP: begin value = {8'h00, ink[23:0]}; nbytes = 3'd3; end
        grb_pkg::DEPTH_16BPP: begin
          value  = {16'h0000, ink[23:19], ink[15:10], ink[7:3]};
          nbytes = 3'd2;
        end
        grb_pkg::DEPTH_8BPP: begin value = {24'h000000, ink[7:0]}; nbytes = 3'd1; end
        default:             begin value = '0; nbytes = '0; depth_ok = 1'b0; end
      endcase
      for (int row = 0; row < ROWS_PER_GLYPH; row++) begin
        glyph        = font_copy[{code, 4'(row)}];
        r.row_offset = '0;
        r.pixel_mask = '0;
        line = int'(py) + row;
        if (line >= 0 && line < height_cfg) begin
          r.row_offset = 26'(line * pitch_cfg);
          if (depth_ok) begin
            for (int k = 0; k < 8; k++) begin
              col = int'(px) + k;
              if (glyph[7-k] && col >= 0 && col < width_cfg) r.pixel_mask[7-k] = 1'b1;
            end
          end
        end
        r.first_column = px;
        r.pixel_value  = value;
        r.pixel_bytes  = nbytes;
        r.last_row     = (row == ROWS_PER_GLYPH - 1);
        row_results_due.push_back(r);
      end
    end
  endtask

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%t: row %0d %s mismatch: expected %h, got %h",
                 $realtime, rows_checked, name, want, got);
    end
  endfunction

  task automatic check_row();
    row_result_t want;
    if (row_results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%t: unexpected row result, tdata %h", $realtime, m_axis_tdata);
    end else begin
      want = row_results_due.pop_front();
      check_field("row_offset",   want.row_offset,   m_axis_tdata[25:0]);
      check_field("first_column", want.first_column, m_axis_tdata[38:26]);
      check_field("pixel_mask",   want.pixel_mask,   m_axis_tdata[46:39]);
      check_field("pixel_value",  want.pixel_value,  m_axis_tdata[78:47]);
      check_field("pixel_bytes",  want.pixel_bytes,  m_axis_tdata[81:79]);
      check_field("last_row",     want.last_row,     m_axis_tlast);
      rows_checked++;
    end
  endtask

  // Driver: present the next item once the current one is taken, idle at random
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet_sides || ($urandom_range(99) >= IDLE_PCT);
      if (!s_axis_tvalid || in_taken) begin
        if (cmd_backlog.size() != 0 && (quiet_sides || $urandom_range(99) >= IDLE_PCT)) begin
          pending_cmd = cmd_backlog.pop_front();
          s_axis_tuser  <= pending_cmd.mode;
          s_axis_tdata  <= pending_cmd.data;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each accepted item, then compare each accepted row
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) predict_rows(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_row();
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%t: no handshake for %0d cycles, %0d rows still due",
                 $realtime, STALL_LIMIT, row_results_due.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = grb_pkg::CFG_SCREEN_WIDTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_LOAD;
    m_axis_tready = 1'b0;
    quiet_cycles  = 0;
    mismatches    = 0;
    rows_checked  = 0;
    loads_sent    = 0;
    draws_sent    = 0;
    settings_used = 1;
    for (int c = 0; c < 256; c++) begin
      rows_loaded[c] = '0;
      char_ready[c]  = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default screen: one edge-pattern glyph drawn across every clip boundary
    for (int r = 0; r < ROWS_PER_GLYPH; r++) queue_load(8'hFF, 4'(r), edge_glyph[r]);
    queue_draw(8'hFF, 13'd0,     13'd0,     32'h1234_5678);
    queue_draw(8'hFF, -13'sd4096, -13'sd4096, 32'hFFFF_FFFF);
    queue_draw(8'hFF, 13'd4095,  13'd4095,  32'h0000_0000);
    queue_draw(8'hFF, -13'sd3,   -13'sd5,   32'hA5A5_A5A5);
    queue_draw(8'hFF, 13'd1020,  13'd760,   32'h00FF_8040);
    queue_draw(8'hFF, 13'd1017,  13'd0,     32'h5A5A_5A5A);
    random_items(PHASE_ITEMS);

    for (int ph = 0; ph < 7; ph++) begin
      settle();
      if (ph == 6) begin
        set_width[ph]  = $urandom_range(1, 4096);
        set_height[ph] = $urandom_range(1, 4096);
        set_pitch[ph]  = $urandom_range(1, 16384);
        set_depth[ph]  = 6'(8 * $urandom_range(1, 4));
      end
      write_reg(grb_pkg::CFG_PIXEL_DEPTH,   set_depth[ph]);
      write_reg(grb_pkg::CFG_SCREEN_WIDTH,  set_width[ph]);
      write_reg(grb_pkg::CFG_LINE_PITCH,    set_pitch[ph]);
      write_reg(grb_pkg::CFG_SCREEN_HEIGHT, set_height[ph]);
      settings_used++;
      quiet_sides = (ph == 2);
      if (ph == 0)
        for (int r = 0; r < ROWS_PER_GLYPH; r++) queue_load(8'h00, 4'(r), 8'($urandom));
      random_items(PHASE_ITEMS);
    end
    settle();

    $display("Run covered %0d glyph row loads and %0d character draws over %0d screen settings",
             loads_sent, draws_sent, settings_used);
    $display("%0d row results compared, %0d mismatches", rows_checked, mismatches);
    if (mismatches == 0 && row_results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
